>>> src/sma_pkg.sv
package sma_pkg;

  // Pool geometry
  localparam int SEG_BYTES = 8;
  localparam int SEG_COUNT = 2048;
  localparam int IDX_W     = $clog2(SEG_COUNT);
  localparam int CNT_W     = IDX_W + 1;

  // Field widths
  localparam int REQ_W = 15;
  localparam int OFS_W = 14;

  typedef logic [1:0] mark_t;

  // Segment marks
  localparam mark_t MARK_FREE = 2'd0;
  localparam mark_t MARK_HEAD = 2'd1;
  localparam mark_t MARK_CONT = 2'd2;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Response status
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SCAN,
    OP_MARK,
    OP_REL_HEAD,
    OP_WALK
  } dp_op_e;

  // Response to publish
  typedef enum logic [1:0] {
    RES_NONE,
    RES_FAIL,
    RES_GRANT,
    RES_FREED
  } res_e;

  typedef struct packed {
    dp_op_e op;
    res_e   res;
  } sma_cmd_t;

  typedef struct packed {
    logic is_free;
    logic rel_bad;
    logic need_bad;
    logic found;
    logic scan_end;
    logic mark_last;
    logic head;
    logic walk_end;
    logic clr_last;
  } sma_sts_t;

endpackage

>>> src/sma_req_if.sv
interface sma_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [sma_pkg::REQ_W-1:0]  request_bytes;
  logic [sma_pkg::OFS_W-1:0]  release_offset;

  modport source (output valid, kind, request_bytes, release_offset, input ready);
  modport sink   (input valid, kind, request_bytes, release_offset, output ready);
endinterface

>>> src/sma_rsp_if.sv
interface sma_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [sma_pkg::OFS_W-1:0]  grant_offset;

  modport source (output valid, status, grant_offset, input ready);
  modport sink   (input valid, status, grant_offset, output ready);
endinterface

>>> src/sma_ctrl.sv
module sma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  input  sma_pkg::sma_sts_t sts_i,
  output sma_pkg::sma_cmd_t cmd_o
);
  import sma_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_MARK,
    ST_HCHK,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e state_q;
  res_e   res_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.res = RES_NONE;
    unique case (state_q)
      ST_CLEAR: cmd_o.op = OP_CLR;
      ST_IDLE:  if (req_valid_i) cmd_o.op = OP_LOAD;
      ST_PREP:  cmd_o.op = OP_NONE;
      ST_SCAN:  cmd_o.op = OP_SCAN;
      ST_MARK:  cmd_o.op = OP_MARK;
      ST_HCHK:  if (sts_i.head) cmd_o.op = OP_REL_HEAD;
      ST_WALK:  cmd_o.op = OP_WALK;
      ST_DONE:  if (out_free) cmd_o.res = res_q;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_q       <= RES_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid_i) state_q <= ST_PREP;
        end
        ST_PREP: begin
          if (sts_i.is_free) begin
            if (sts_i.rel_bad) begin
              res_q   <= RES_FAIL;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_HCHK;
            end
          end else if (sts_i.need_bad) begin
            res_q   <= RES_FAIL;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.found) begin
            state_q <= ST_MARK;
          end else if (sts_i.scan_end) begin
            res_q   <= RES_FAIL;
            state_q <= ST_DONE;
          end
        end
        ST_MARK: begin
          if (sts_i.mark_last) begin
            res_q   <= RES_GRANT;
            state_q <= ST_DONE;
          end
        end
        ST_HCHK: begin
          if (sts_i.head) begin
            state_q <= ST_WALK;
          end else begin
            res_q   <= RES_FAIL;
            state_q <= ST_DONE;
          end
        end
        ST_WALK: begin
          if (sts_i.walk_end) begin
            res_q   <= RES_FREED;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/sma_dp.sv
module sma_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sma_pkg::sma_cmd_t          cmd_i,
  output sma_pkg::sma_sts_t          sts_o,
  input  logic                       kind_i,
  input  logic [sma_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [sma_pkg::OFS_W-1:0]  release_offset_i,
  output logic                       status_o,
  output logic [sma_pkg::OFS_W-1:0]  grant_offset_o
);
  import sma_pkg::*;

  localparam logic [CNT_W-1:0] PTR_END  = CNT_W'(SEG_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEG_COUNT - 1);

  // Segment mark store
  mark_t mem [SEG_COUNT];
  mark_t rd_data_q;

  // Control registers
  logic [CNT_W-1:0] ptr_q;
  logic             chk_v_q;

  // Request and scan registers
  logic             kind_q;
  logic [REQ_W-1:0] need_q;
  logic             rel_bad_q;
  logic [IDX_W-1:0] chk_q;
  logic [CNT_W-1:0] run_q;
  logic [IDX_W-1:0] start_q;
  logic [IDX_W-1:0] end_q;
  logic             status_q;
  logic [OFS_W-1:0] ofs_q;

  logic [REQ_W-1:0] need_d;
  logic [OFS_W-1:0] seg_d;
  logic [CNT_W-1:0] run_inc;
  logic             is_free_mark;
  logic             found;
  logic [IDX_W-1:0] start_d;
  logic             walk_cont;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  mark_t            wr_data;

  // Request decode
  assign need_d = REQ_W'(request_bytes_i / SEG_BYTES)
                + REQ_W'((request_bytes_i % SEG_BYTES) != 0);
  assign seg_d  = OFS_W'(release_offset_i / SEG_BYTES);

  // First-fit run tracking
  assign run_inc      = run_q + CNT_W'(1);
  assign is_free_mark = (rd_data_q == MARK_FREE);
  assign found        = chk_v_q && is_free_mark && (32'(run_inc) == 32'(need_q));
  assign start_d      = IDX_W'(32'(chk_q) + 1 - 32'(need_q));
  assign walk_cont    = chk_v_q && (rd_data_q == MARK_CONT);

  // Status to controller
  always_comb begin
    sts_o.is_free   = (kind_q == KIND_FREE);
    sts_o.rel_bad   = rel_bad_q;
    sts_o.need_bad  = (need_q == '0) || (32'(need_q) > SEG_COUNT);
    sts_o.found     = found;
    sts_o.scan_end  = chk_v_q && (chk_q == IDX_LAST);
    sts_o.mark_last = (ptr_q[IDX_W-1:0] == end_q);
    sts_o.head      = (rd_data_q == MARK_HEAD);
    sts_o.walk_end  = (chk_v_q && (!walk_cont || chk_q == IDX_LAST))
                    || (!chk_v_q && ptr_q == PTR_END);
    sts_o.clr_last  = (ptr_q[IDX_W-1:0] == IDX_LAST);
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q[IDX_W-1:0];
    wr_data = MARK_FREE;
    unique case (cmd_i.op)
      OP_CLR:      wr_en = 1'b1;
      OP_MARK: begin
        wr_en   = 1'b1;
        wr_data = (ptr_q[IDX_W-1:0] == start_q) ? MARK_HEAD : MARK_CONT;
      end
      OP_REL_HEAD: wr_en = 1'b1;
      OP_WALK: begin
        wr_en   = walk_cont;
        wr_addr = chk_q;
      end
      default:     wr_en = 1'b0;
    endcase
  end

  // Mark store: one write, one registered read at the pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[ptr_q[IDX_W-1:0]];
  end

  // Pointer and read-check valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_CLR:  ptr_q <= ptr_q + CNT_W'(1);
        OP_LOAD: begin
          ptr_q   <= (kind_i == KIND_FREE) ? CNT_W'(32'(seg_d)) : '0;
          chk_v_q <= 1'b0;
        end
        OP_SCAN, OP_WALK: begin
          if (cmd_i.op == OP_SCAN && found) begin
            ptr_q <= CNT_W'(start_d);
          end else begin
            if (ptr_q != PTR_END) ptr_q <= ptr_q + CNT_W'(1);
            chk_v_q <= (ptr_q != PTR_END);
          end
        end
        OP_MARK: ptr_q <= ptr_q + CNT_W'(1);
        OP_REL_HEAD: begin
          ptr_q   <= ptr_q + CNT_W'(1);
          chk_v_q <= 1'b0;
        end
        default: ptr_q <= ptr_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      kind_q    <= kind_i;
      need_q    <= need_d;
      rel_bad_q <= (32'(seg_d) >= SEG_COUNT);
      run_q     <= '0;
    end
    if (cmd_i.op == OP_SCAN || cmd_i.op == OP_WALK) begin
      chk_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.op == OP_SCAN && chk_v_q) begin
      run_q <= is_free_mark ? run_inc : '0;
    end
    if (cmd_i.op == OP_SCAN && found) begin
      start_q <= start_d;
      end_q   <= chk_q;
    end
    // Response payload
    unique case (cmd_i.res)
      RES_FAIL: begin
        status_q <= STAT_FAIL;
        ofs_q    <= '0;
      end
      RES_GRANT: begin
        status_q <= STAT_OK;
        ofs_q    <= OFS_W'(32'(start_q) * SEG_BYTES);
      end
      RES_FREED: begin
        status_q <= STAT_OK;
        ofs_q    <= '0;
      end
      default: status_q <= status_q;
    endcase
  end

  assign status_o       = status_q;
  assign grant_offset_o = ofs_q;

endmodule

>>> src/segment_map_first_fit_allocator_unit.sv
// Allocate: the scan reads one segment mark per cycle from the mark store (one write
//   port, one registered read port), then marks the first fitting run.
// Free: the head segment is cleared, then one continuation segment cleared per cycle.
// One request in flight at a time; the next is taken while a response still waits.
// Reset: asynchronous, active low; then a clearing pass over all 2048 segments of the mark
//   store, during which no request is accepted.
module segment_map_first_fit_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sma_req_if.sink    req_i,
  sma_rsp_if.source  rsp_o
);
  import sma_pkg::*;

  sma_cmd_t cmd;
  sma_sts_t sts;

  sma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sma_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (req_i.kind),
    .request_bytes_i  (req_i.request_bytes),
    .release_offset_i (req_i.release_offset),
    .status_o         (rsp_o.status),
    .grant_offset_o   (rsp_o.grant_offset)
  );

endmodule
